>>> sv/jtx_pkg.sv
// ============================================================================
// jtx_pkg - shared definitions for the J1850 transmit symbol encoder
// Transaction types, command and symbol codes, status codes and the FIFO
// geometry used by the front end, the command queue, the byte store and the
// symbol engine.
// ============================================================================
package jtx_pkg;

   localparam int FIFO_DEPTH  = 64;
   localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_PWM_MODE    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SOF_CODE    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ESCAPE_CODE = 2'd2;

   localparam logic [7:0] SOF_CODE_RESET    = 8'd126;
   localparam logic [7:0] ESCAPE_CODE_RESET = 8'd125;
   localparam logic [7:0] ESCAPE_XOR        = 8'h80;

   localparam logic [1:0] CMD_PUSH  = 2'd0;
   localparam logic [1:0] CMD_START = 2'd1;
   localparam logic [1:0] CMD_NEXT  = 2'd2;

   localparam logic [3:0] SYM_SOF0 = 4'd0;
   localparam logic [3:0] SYM_SOF1 = 4'd1;
   localparam logic [3:0] SYM_EOD  = 4'd2;
   localparam logic [3:0] SYM_BRK0 = 4'd4;
   localparam logic [3:0] SYM_BRK1 = 4'd5;
   localparam logic [3:0] SYM_PAS0 = 4'd7;
   localparam logic [3:0] SYM_PAS1 = 4'd8;
   localparam logic [3:0] SYM_ACT0 = 4'd9;
   localparam logic [3:0] SYM_ACT1 = 4'd10;

   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_FULL = 2'd1;
   localparam logic [1:0] STATUS_IDLE = 2'd2;

   typedef enum logic [1:0] {
      OP_PUSH,
      OP_START,
      OP_NEXT,
      OP_NOP
   } op_type;

   typedef struct packed {
      logic [1:0] command;
      logic [7:0] data_byte;
      logic       line_level;
   } req_type;

   typedef struct packed {
      logic       drive_level;
      logic [8:0] symbol_us;
      logic [3:0] symbol_code;
      logic       busy_res;
      logic [1:0] status;
      logic [6:0] fifo_level;
   } rsp_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] data_byte;
      logic       line_level;
   } queue_entry_type;

   typedef struct packed {
      logic       push;
      logic [7:0] push_byte;
      logic [1:0] pop_count;
   } store_ctrl_type;

   typedef struct packed {
      logic       ready;
      logic [7:0] win0;
      logic [7:0] win1;
   } store_stat_type;

endpackage

>>> sv/j1850_tx_symbol_encoder_unit.sv
// ============================================================================
// j1850_tx_symbol_encoder_unit - J1850 VPW/PWM transmit symbol encoder
// Buffers transmit bytes and turns them, one command at a time, into bus
// symbols (level and nominal duration) for a VPW or PWM line driver.
// ============================================================================
//
//   Channel   Handshake            Payload     Direction
//   req_      req_valid/req_ready  req_type    in:  push, start, next symbol
//   rsp_      rsp_valid/rsp_ready  rsp_type    out: one response per command
//   csr_      csr_we (no wait)     index/data  in:  mode, SOF and escape codes
//
// Every request transaction produces exactly one response transaction, in
// order. One transaction per clock is sustained while the response channel
// is not stalled and no start or next-symbol command that needs FIFO bytes
// waits after a byte pop while the two-byte window refills from the byte
// memory's registered read port.
// Reset is synchronous; it empties the FIFO, closes any frame and restores
// the register defaults. A stalled response holds in the output register
// while the two-entry command queue keeps taking requests until it fills.
//
// The front end decodes each command into an operation and hands it to the
// command queue. The symbol engine executes the queue head: it keeps the
// frame state (pending symbol, bit shifter, last bus level, in-frame flag)
// and the FIFO byte count, and it registers the response. The byte store
// holds the FIFO bytes in a memory and presents the two oldest bytes so that
// an escape code and the byte it modifies can be taken together.
// ============================================================================
module j1850_tx_symbol_encoder_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  jtx_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output jtx_pkg::rsp_type               rsp_data,
   input  logic                           csr_we,
   input  logic [jtx_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [jtx_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import jtx_pkg::*;

   logic            fq_valid, fq_ready;
   queue_entry_type fq_entry;
   logic            qe_valid, qe_ready;
   queue_entry_type qe_entry;
   store_ctrl_type  store_ctrl;
   store_stat_type  store_stat;

   // Command intake and classification.
   jtx_front u_front (
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_valid   (fq_valid),
      .q_ready   (fq_ready),
      .q_entry   (fq_entry)
   );

   // Decouples intake from execution.
   jtx_cmd_queue u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fq_valid),
      .in_ready  (fq_ready),
      .in_entry  (fq_entry),
      .out_valid (qe_valid),
      .out_ready (qe_ready),
      .out_entry (qe_entry)
   );

   // Transmit byte FIFO with a two-byte look-ahead window.
   jtx_byte_store u_byte_store (
      .clock (clock),
      .reset (reset),
      .ctrl  (store_ctrl),
      .stat  (store_stat)
   );

   // Frame sequencing, symbol generation and the response register.
   jtx_symbol_engine u_symbol_engine (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .q_valid    (qe_valid),
      .q_ready    (qe_ready),
      .q_entry    (qe_entry),
      .store_ctrl (store_ctrl),
      .store_stat (store_stat),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

>>> sv/jtx_front.sv
// ============================================================================
// jtx_front - command intake
// Takes request transactions and classifies the command code into an
// operation for the command queue.
// ============================================================================
module jtx_front (
   input  logic                     req_valid,
   output logic                     req_ready,
   input  jtx_pkg::req_type         req_data,
   output logic                     q_valid,
   input  logic                     q_ready,
   output jtx_pkg::queue_entry_type q_entry
);
   import jtx_pkg::*;

   op_type op;

   always_comb begin
      unique case (req_data.command)
         CMD_PUSH:  op = OP_PUSH;
         CMD_START: op = OP_START;
         CMD_NEXT:  op = OP_NEXT;
         default:   op = OP_NOP;
      endcase
   end

   assign q_valid            = req_valid;
   assign req_ready          = q_ready;
   assign q_entry.op         = op;
   assign q_entry.data_byte  = req_data.data_byte;
   assign q_entry.line_level = req_data.line_level;

endmodule

>>> sv/jtx_cmd_queue.sv
// ============================================================================
// jtx_cmd_queue - short command queue
// Small register FIFO between the command intake and the symbol engine so
// that either side can stall without holding up the other.
// ============================================================================
module jtx_cmd_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  jtx_pkg::queue_entry_type in_entry,
   output logic                     out_valid,
   input  logic                     out_ready,
   output jtx_pkg::queue_entry_type out_entry
);
   import jtx_pkg::*;

   queue_entry_type        entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   do_write, do_read;

   assign in_ready  = (count_ff != QUEUE_CNT_W'(QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_entry = entries_ff[rd_ptr_ff];
   assign do_write  = in_valid && in_ready;
   assign do_read   = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_write) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_read) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + QUEUE_CNT_W'(do_write) - QUEUE_CNT_W'(do_read);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_write) begin
         entries_ff[wr_ptr_ff] <= in_entry;
      end
   end

endmodule

>>> sv/jtx_byte_store.sv
// ============================================================================
// jtx_byte_store - transmit byte FIFO
// A memory with a registered read port behind a two-byte window that always
// shows the oldest bytes, so the symbol engine can take one or two bytes at
// once.
// ============================================================================
module jtx_byte_store (
   input  logic                    clock,
   input  logic                    reset,
   input  jtx_pkg::store_ctrl_type ctrl,
   output jtx_pkg::store_stat_type stat
);
   import jtx_pkg::*;

   logic [7:0]            mem [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0] mem_cnt_ff, mem_cnt_in;
   logic                  rd_valid_ff, rd_valid_in;
   logic [7:0]            rd_data_ff;
   logic [1:0]            win_cnt_ff, win_cnt_in;
   logic [7:0]            win0_ff, win0_in;
   logic [7:0]            win1_ff, win1_in;
   logic [1:0]            cnt_after_pop, cnt_after_fill;
   logic                  push_direct, push_mem, rd_issue;

   always_comb begin
      // Drop the bytes taken this cycle.
      cnt_after_pop = win_cnt_ff - ctrl.pop_count;
      win0_in = (ctrl.pop_count == 2'd1) ? win1_ff : win0_ff;
      win1_in = win1_ff;

      // The byte read from memory last cycle lands behind what is left.
      cnt_after_fill = cnt_after_pop;
      if (rd_valid_ff) begin
         if (cnt_after_pop == 2'd0) begin
            win0_in = rd_data_ff;
         end else begin
            win1_in = rd_data_ff;
         end
         cnt_after_fill = cnt_after_pop + 2'd1;
      end

      // A pushed byte skips the memory when nothing older is stored there and the window has a free slot.
      push_direct = ctrl.push && (mem_cnt_ff == '0) && (cnt_after_fill != 2'd2);
      push_mem    = ctrl.push && !push_direct;
      win_cnt_in  = cnt_after_fill;
      if (push_direct) begin
         if (cnt_after_fill == 2'd0) begin
            win0_in = ctrl.push_byte;
         end else begin
            win1_in = ctrl.push_byte;
         end
         win_cnt_in = cnt_after_fill + 2'd1;
      end

      rd_issue    = (mem_cnt_ff != '0) && (cnt_after_fill != 2'd2);
      rd_valid_in = rd_issue;
      mem_cnt_in  = mem_cnt_ff + FIFO_CNT_W'(push_mem) - FIFO_CNT_W'(rd_issue);
      wr_ptr_in   = wr_ptr_ff;
      rd_ptr_in   = rd_ptr_ff;
      if (push_mem) begin
         wr_ptr_in = (wr_ptr_ff == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (rd_issue) begin
         rd_ptr_in = (rd_ptr_ff == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
   end

   // The window is trustworthy once no byte is on its way from the memory
   // into a free window slot.
   assign stat.ready = (win_cnt_ff == 2'd2) || ((mem_cnt_ff == '0) && !rd_valid_ff);
   assign stat.win0  = win0_ff;
   assign stat.win1  = win1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         mem_cnt_ff  <= '0;
         rd_valid_ff <= 1'b0;
         win_cnt_ff  <= 2'd0;
      end else begin
         wr_ptr_ff   <= wr_ptr_in;
         rd_ptr_ff   <= rd_ptr_in;
         mem_cnt_ff  <= mem_cnt_in;
         rd_valid_ff <= rd_valid_in;
         win_cnt_ff  <= win_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      win0_ff <= win0_in;
      win1_ff <= win1_in;
      if (push_mem) begin
         mem[wr_ptr_ff] <= ctrl.push_byte;
      end
      if (rd_issue) begin
         rd_data_ff <= mem[rd_ptr_ff];
      end
   end

endmodule

>>> sv/jtx_symbol_engine.sv
// ============================================================================
// jtx_symbol_engine - frame and symbol sequencer
// Executes queued commands: pushes bytes, opens frames, turns FIFO bytes into
// bus symbols with their nominal durations, and registers one response per
// command. Also holds the configuration registers.
// ============================================================================
module jtx_symbol_engine (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [jtx_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [jtx_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                           q_valid,
   output logic                           q_ready,
   input  jtx_pkg::queue_entry_type       q_entry,
   output jtx_pkg::store_ctrl_type        store_ctrl,
   input  jtx_pkg::store_stat_type        store_stat,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output jtx_pkg::rsp_type               rsp_data
);
   import jtx_pkg::*;

   typedef struct packed {
      logic [3:0] sym;
      logic [3:0] bits_left;
      logic [7:0] shifter;
      logic [1:0] pops;
   } fetch_type;

   // Next symbol from the bit shifter or, when it is empty, from the oldest
   // FIFO bytes (w0 first, w1 after an escape).
   function automatic fetch_type fetch_sym(
      input logic [3:0]            bits,
      input logic [7:0]            shift,
      input logic [FIFO_CNT_W-1:0] count,
      input logic [7:0]            w0,
      input logic [7:0]            w1,
      input logic                  fresh,
      input logic                  pwm,
      input logic                  last,
      input logic [7:0]            sof,
      input logic [7:0]            esc
   );
      fetch_type  r;
      logic [7:0] ch;
      logic       load;
      logic       emit;
      logic       bitv;
      r.bits_left = bits;
      r.shifter   = shift;
      r.pops      = 2'd0;
      r.sym       = SYM_EOD;
      ch          = w0;
      load        = 1'b0;
      if (bits == 4'd0) begin
         if (count != '0) begin
            r.pops = 2'd1;
            if (w0 == sof) begin
               r.sym = fresh ? SYM_SOF1 : SYM_EOD;
            end else if (w0 == esc) begin
               if (count == FIFO_CNT_W'(1)) begin
                  r.sym = SYM_BRK1;
               end else begin
                  ch     = w1 ^ ESCAPE_XOR;
                  r.pops = 2'd2;
                  load   = 1'b1;
               end
            end else begin
               load = 1'b1;
            end
         end
      end
      emit = (bits != 4'd0) || load;
      if (load) begin
         r.shifter   = ch;
         r.bits_left = 4'd8;
      end
      if (emit) begin
         bitv        = r.shifter[7];
         r.bits_left = r.bits_left - 4'd1;
         r.shifter   = {r.shifter[6:0], 1'b0};
         if (!pwm && last) begin
            r.sym = bitv ? SYM_PAS1 : SYM_PAS0;
         end else begin
            r.sym = bitv ? SYM_ACT1 : SYM_ACT0;
         end
      end
      return r;
   endfunction

   function automatic logic [8:0] duration_of(input logic pwm, input logic [3:0] sym);
      logic [8:0] d;
      case (sym)
         SYM_SOF0: d = pwm ? 9'd17 : 9'd0;
         SYM_SOF1: d = pwm ? 9'd31 : 9'd200;
         SYM_EOD:  d = pwm ? 9'd48 : 9'd200;
         SYM_BRK0: d = pwm ? 9'd9  : 9'd0;
         SYM_BRK1: d = pwm ? 9'd39 : 9'd300;
         SYM_PAS0: d = pwm ? 9'd8  : 9'd64;
         SYM_PAS1: d = pwm ? 9'd16 : 9'd128;
         SYM_ACT0: d = pwm ? 9'd16 : 9'd128;
         SYM_ACT1: d = pwm ? 9'd8  : 9'd64;
         default:  d = 9'd0;
      endcase
      return d;
   endfunction

   logic [3:0]            next_sym_ff, next_sym_in;
   logic [3:0]            bits_left_ff, bits_left_in;
   logic [7:0]            shifter_ff, shifter_in;
   logic                  level_last_ff, level_last_in;
   logic                  sending_ff, sending_in;
   logic [FIFO_CNT_W-1:0] count_ff, count_in;
   logic                  pwm_mode_ff, pwm_mode_in;
   logic [7:0]            sof_code_ff, sof_code_in;
   logic [7:0]            escape_code_ff, escape_code_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   fetch_type             fa, fb;
   logic                  is_start, needs_bytes, out_free, fire;
   logic                  use_fa, use_fb, push_ok;
   logic [3:0]            s;
   logic [3:0]            mid_bits;
   logic [7:0]            mid_shift;
   logic [FIFO_CNT_W-1:0] mid_count;
   logic [1:0]            pops_total;
   logic                  ll_new;

   assign is_start    = (q_entry.op == OP_START);
   assign needs_bytes = (is_start && !sending_ff) || ((q_entry.op == OP_NEXT) && sending_ff);
   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign fire        = q_valid && out_free && (!needs_bytes || store_stat.ready);
   assign q_ready     = out_free && (!needs_bytes || store_stat.ready);

   always_comb begin
      // First fetch: a frame start, or the hidden VPW SOF0 step.
      fa = fetch_sym(is_start ? 4'd0 : bits_left_ff, shifter_ff, count_ff,
                     store_stat.win0, store_stat.win1, is_start, pwm_mode_ff,
                     level_last_ff, sof_code_ff, escape_code_ff);

      s      = (next_sym_ff > SYM_ACT1) ? SYM_ACT1 : next_sym_ff;
      use_fa = (s == SYM_SOF0) && !pwm_mode_ff;
      if (use_fa) begin
         s         = fa.sym;
         mid_bits  = fa.bits_left;
         mid_shift = fa.shifter;
         mid_count = count_ff - FIFO_CNT_W'(fa.pops);
      end else begin
         mid_bits  = bits_left_ff;
         mid_shift = shifter_ff;
         mid_count = count_ff;
      end

      ll_new = level_last_ff;
      use_fb = 1'b0;
      case (s) inside
         SYM_SOF1, SYM_BRK1: ll_new = 1'b1;
         SYM_SOF0, SYM_PAS0, SYM_PAS1: begin
            ll_new = 1'b0;
            use_fb = 1'b1;
         end
         SYM_ACT0, SYM_ACT1: begin
            ll_new = 1'b1;
            use_fb = !pwm_mode_ff;
         end
         SYM_BRK0, SYM_EOD: ll_new = 1'b0;
         default: ll_new = level_last_ff;
      endcase

      fb = fetch_sym(mid_bits, mid_shift, mid_count, store_stat.win0, store_stat.win1,
                     1'b0, pwm_mode_ff, ll_new, sof_code_ff, escape_code_ff);

      next_sym_in   = next_sym_ff;
      bits_left_in  = bits_left_ff;
      shifter_in    = shifter_ff;
      level_last_in = level_last_ff;
      sending_in    = sending_ff;
      pops_total    = 2'd0;
      push_ok       = 1'b0;
      rsp_data_in   = '0;

      case (q_entry.op)
         OP_PUSH: begin
            if (count_ff >= FIFO_CNT_W'(FIFO_DEPTH)) begin
               rsp_data_in.status = STATUS_FULL;
            end else begin
               push_ok = 1'b1;
            end
         end
         OP_START: begin
            if (!sending_ff) begin
               next_sym_in   = fa.sym;
               bits_left_in  = fa.bits_left;
               shifter_in    = fa.shifter;
               pops_total    = fa.pops;
               sending_in    = 1'b1;
               level_last_in = q_entry.line_level;
            end
         end
         OP_NEXT: begin
            if (sending_ff) begin
               level_last_in = ll_new;
               bits_left_in  = mid_bits;
               shifter_in    = mid_shift;
               pops_total    = use_fa ? fa.pops : 2'd0;
               if (use_fb) begin
                  next_sym_in  = fb.sym;
                  bits_left_in = fb.bits_left;
                  shifter_in   = fb.shifter;
                  pops_total   = pops_total + fb.pops;
               end else begin
                  case (s)
                     SYM_SOF1: next_sym_in = SYM_SOF0;
                     SYM_BRK0: next_sym_in = SYM_EOD;
                     SYM_BRK1: next_sym_in = pwm_mode_ff ? SYM_BRK0 : SYM_EOD;
                     SYM_ACT0: next_sym_in = SYM_PAS0;
                     SYM_ACT1: next_sym_in = SYM_PAS1;
                     SYM_EOD:  sending_in  = 1'b0;
                     default:  next_sym_in = s;
                  endcase
               end
               rsp_data_in.drive_level = ll_new;
               rsp_data_in.symbol_us   = duration_of(pwm_mode_ff, s);
               rsp_data_in.symbol_code = s;
            end else begin
               rsp_data_in.status = STATUS_IDLE;
            end
         end
         default: rsp_data_in.status = STATUS_IDLE;
      endcase

      count_in = count_ff + FIFO_CNT_W'(push_ok) - FIFO_CNT_W'(pops_total);
      rsp_data_in.busy_res   = sending_in;
      rsp_data_in.fifo_level = 7'(count_in);

      rsp_valid_in = fire ? 1'b1 : (rsp_valid_ff && !rsp_ready);

      pwm_mode_in    = pwm_mode_ff;
      sof_code_in    = sof_code_ff;
      escape_code_in = escape_code_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_PWM_MODE:    pwm_mode_in    = csr_wdata[0];
            CSR_SOF_CODE:    sof_code_in    = csr_wdata[7:0];
            CSR_ESCAPE_CODE: escape_code_in = csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   assign store_ctrl.push      = fire && push_ok;
   assign store_ctrl.push_byte = q_entry.data_byte;
   assign store_ctrl.pop_count = fire ? pops_total : 2'd0;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         next_sym_ff    <= SYM_EOD;
         bits_left_ff   <= 4'd0;
         shifter_ff     <= 8'd0;
         level_last_ff  <= 1'b0;
         sending_ff     <= 1'b0;
         count_ff       <= '0;
         pwm_mode_ff    <= 1'b0;
         sof_code_ff    <= SOF_CODE_RESET;
         escape_code_ff <= ESCAPE_CODE_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (fire) begin
            next_sym_ff   <= next_sym_in;
            bits_left_ff  <= bits_left_in;
            shifter_ff    <= shifter_in;
            level_last_ff <= level_last_in;
            sending_ff    <= sending_in;
            count_ff      <= count_in;
         end
         pwm_mode_ff    <= pwm_mode_in;
         sof_code_ff    <= sof_code_in;
         escape_code_ff <= escape_code_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

>>> sv/jtx_checker.sv
// ============================================================================
// jtx_checker - port-level checks for the J1850 transmit symbol encoder
// Watches the request and response channels of the top level and checks the
// relations between response fields.
// ============================================================================
module jtx_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input jtx_pkg::req_type               req_data,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input jtx_pkg::rsp_type               rsp_data
);
   import jtx_pkg::*;

   // A request that is not taken stays offered, unchanged.
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_data))
      else $error("request changed or withdrawn while waiting");

   // A response that is not taken stays, unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed or dropped while stalled");

   // A dropped byte is only reported when the FIFO is full.
   a_full_level: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == STATUS_FULL) |->
         (rsp_data.fifo_level == 7'(FIFO_DEPTH)))
      else $error("FIFO full reported below full level");

   // An idle response carries no symbol.
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == STATUS_IDLE) |->
         !rsp_data.drive_level && (rsp_data.symbol_us == 9'd0) &&
         (rsp_data.symbol_code == SYM_SOF0))
      else $error("idle response carries a symbol");

   // End of data always closes the frame with the bus passive.
   a_eod_closes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.symbol_code == SYM_EOD) |->
         !rsp_data.busy_res && !rsp_data.drive_level)
      else $error("end of data left the frame open or the bus active");

endmodule

bind j1850_tx_symbol_encoder_unit jtx_checker u_checker (.*);
